### sv/mkrl_pkg.sv
package mkrl_pkg;

    // Field widths of one word on the command and result sides.
    localparam int KEY_W  = 24;
    localparam int ADDR_W = 24;
    localparam int SEL_W  = 16;
    localparam int MAP_W  = 8;
    localparam int MASK_W = 4;
    localparam int VER_W  = 8;
    localparam int IDX_W  = 9;
    localparam int CNT_W  = 10;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam int TABLE_DEPTH_DEF = 512;

    // Opcodes of a command word.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Bit positions inside an entry mask.
    localparam int M_CALLER   = 0;
    localparam int M_CONTEXT  = 1;
    localparam int M_SELECTOR = 2;
    localparam int M_MAP      = 3;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_EXPECTED_VERSION = 3'd0;
    localparam logic [2:0] REG_SCOPE_GROUP      = 3'd1;
    localparam logic [2:0] REG_HOME_MAP         = 3'd2;
    localparam logic [2:0] REG_FIRST_TOWN       = 3'd3;
    localparam logic [2:0] REG_LAST_TOWN        = 3'd4;
    localparam logic [2:0] REG_ENTRIES_USED     = 3'd5;

    // Register reset values.
    localparam logic [VER_W-1:0] RST_EXPECTED_VERSION = 8'd1;
    localparam logic [MAP_W-1:0] RST_SCOPE_GROUP      = 8'd0;
    localparam logic [MAP_W-1:0] RST_HOME_MAP         = 8'd0;
    localparam logic [MAP_W-1:0] RST_FIRST_TOWN       = 8'd1;
    localparam logic [MAP_W-1:0] RST_LAST_TOWN        = 8'd6;
    localparam logic [CNT_W-1:0] RST_ENTRIES_USED     = 10'd0;

    typedef enum logic [1:0] {
        ST_FOUND   = 2'd0,
        ST_MISS    = 2'd1,
        ST_REJECT  = 2'd2,
        ST_WRITTEN = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_SCAN
    } t_state;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_CHECK,
        CMD_SEARCH,
        CMD_SCAN
    } t_cmd_op;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [ADDR_W-1:0] caller;
        logic [ADDR_W-1:0] context_addr;
        logic [SEL_W-1:0]  selector;
        logic [MAP_W-1:0]  map_id;
        logic [MASK_W-1:0] mask;
    } t_entry;

    typedef struct packed {
        logic [VER_W-1:0] expected_version;
        logic [MAP_W-1:0] scope_group;
        logic [MAP_W-1:0] home_map;
        logic [MAP_W-1:0] first_town;
        logic [MAP_W-1:0] last_town;
        logic [CNT_W-1:0] entries_used;
    } t_cfg;

    typedef struct packed {
        t_cmd_op op;
        logic    finish;
        t_status fin_status;
    } t_cmd;

    typedef struct packed {
        logic reject;
        logic more;
        logic scan_ok;
        logic key_eq;
        logic hit;
        logic next_ok;
    } t_dp_status;

endpackage

### sv/masked_key_route_lookup.sv
// Write command: taken with busy staying low; its result strobes the next cycle.
// Lookup: busy through a check step, S binary search probes (at most
// ceil(log2(entries+1)), one table read each) and R entries scanned in the equal-key run; the
// result strobes in the first cycle that busy is low, as the single read port of the route
// table sets the pace. The receiver cannot stall results.
// Synchronous active-low reset clears controller, strobe and configuration registers, not the route table.
module masked_key_route_lookup #(
    parameter int TABLE_DEPTH = mkrl_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_opcode,
    input  logic [mkrl_pkg::IDX_W-1:0]    i_entry_index,
    input  logic [mkrl_pkg::KEY_W-1:0]    i_source_key,
    input  logic [mkrl_pkg::ADDR_W-1:0]   i_caller_addr,
    input  logic [mkrl_pkg::ADDR_W-1:0]   i_context_addr,
    input  logic [mkrl_pkg::SEL_W-1:0]    i_selector_value,
    input  logic [mkrl_pkg::MAP_W-1:0]    i_map_group_in,
    input  logic [mkrl_pkg::MAP_W-1:0]    i_map_number_in,
    input  logic [mkrl_pkg::MASK_W-1:0]   i_match_mask,
    input  logic [mkrl_pkg::VER_W-1:0]    i_version_in,
    output logic                          o_done,
    output mkrl_pkg::t_status             o_status,
    output logic [mkrl_pkg::IDX_W-1:0]    o_route_index,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mkrl_pkg::PADDR_W-1:0]  paddr,
    input  logic [mkrl_pkg::PDATA_W-1:0]  pwdata,
    output logic [mkrl_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import mkrl_pkg::*;

    t_cfg       cfg;
    t_cmd       cmd;
    t_dp_status stat;

    // Configuration registers.
    mkrl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer for write, check, search and scan.
    mkrl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_stat   (stat),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    // Route table, search window and result register.
    mkrl_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_cmd            (cmd),
        .i_opcode         (i_opcode),
        .i_entry_index    (i_entry_index),
        .i_source_key     (i_source_key),
        .i_caller_addr    (i_caller_addr),
        .i_context_addr   (i_context_addr),
        .i_selector_value (i_selector_value),
        .i_map_group_in   (i_map_group_in),
        .i_map_number_in  (i_map_number_in),
        .i_match_mask     (i_match_mask),
        .i_version_in     (i_version_in),
        .o_stat           (stat),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_route_index    (o_route_index)
    );

endmodule

### sv/mkrl_cfg.sv
module mkrl_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mkrl_pkg::PADDR_W-1:0]  paddr,
    input  logic [mkrl_pkg::PDATA_W-1:0]  pwdata,
    output logic [mkrl_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output mkrl_pkg::t_cfg                o_cfg
);
    import mkrl_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[4:2];

    // Register writes on the access cycle of a write transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_version <= RST_EXPECTED_VERSION;
            r_cfg.scope_group      <= RST_SCOPE_GROUP;
            r_cfg.home_map         <= RST_HOME_MAP;
            r_cfg.first_town       <= RST_FIRST_TOWN;
            r_cfg.last_town        <= RST_LAST_TOWN;
            r_cfg.entries_used     <= RST_ENTRIES_USED;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_EXPECTED_VERSION: r_cfg.expected_version <= pwdata[VER_W-1:0];
                REG_SCOPE_GROUP:      r_cfg.scope_group      <= pwdata[MAP_W-1:0];
                REG_HOME_MAP:         r_cfg.home_map         <= pwdata[MAP_W-1:0];
                REG_FIRST_TOWN:       r_cfg.first_town       <= pwdata[MAP_W-1:0];
                REG_LAST_TOWN:        r_cfg.last_town        <= pwdata[MAP_W-1:0];
                REG_ENTRIES_USED:     r_cfg.entries_used     <= pwdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        unique case (reg_sel)
            REG_EXPECTED_VERSION: prdata = PDATA_W'(r_cfg.expected_version);
            REG_SCOPE_GROUP:      prdata = PDATA_W'(r_cfg.scope_group);
            REG_HOME_MAP:         prdata = PDATA_W'(r_cfg.home_map);
            REG_FIRST_TOWN:       prdata = PDATA_W'(r_cfg.first_town);
            REG_LAST_TOWN:        prdata = PDATA_W'(r_cfg.last_town);
            REG_ENTRIES_USED:     prdata = PDATA_W'(r_cfg.entries_used);
            default:              prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### sv/mkrl_dp.sv
module mkrl_dp #(
    parameter int TABLE_DEPTH = mkrl_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mkrl_pkg::t_cfg                 i_cfg,
    input  mkrl_pkg::t_cmd                 i_cmd,
    input  logic                           i_opcode,
    input  logic [mkrl_pkg::IDX_W-1:0]     i_entry_index,
    input  logic [mkrl_pkg::KEY_W-1:0]     i_source_key,
    input  logic [mkrl_pkg::ADDR_W-1:0]    i_caller_addr,
    input  logic [mkrl_pkg::ADDR_W-1:0]    i_context_addr,
    input  logic [mkrl_pkg::SEL_W-1:0]     i_selector_value,
    input  logic [mkrl_pkg::MAP_W-1:0]     i_map_group_in,
    input  logic [mkrl_pkg::MAP_W-1:0]     i_map_number_in,
    input  logic [mkrl_pkg::MASK_W-1:0]    i_match_mask,
    input  logic [mkrl_pkg::VER_W-1:0]     i_version_in,
    output mkrl_pkg::t_dp_status           o_stat,
    output logic                           o_done,
    output mkrl_pkg::t_status              o_status,
    output logic [mkrl_pkg::IDX_W-1:0]     o_route_index
);
    import mkrl_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int WW = (CW > CNT_W) ? CW : CNT_W;

    // Route table and its registered read word.
    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd;

    // Lookup word held for the duration of the search.
    logic [KEY_W-1:0]  r_key;
    logic [ADDR_W-1:0] r_caller;
    logic [ADDR_W-1:0] r_context;
    logic [SEL_W-1:0]  r_selector;
    logic [MAP_W-1:0]  r_group;
    logic [MAP_W-1:0]  r_map;
    logic [VER_W-1:0]  r_version;

    // Search window, probe point, scan pointer and clamped entry count.
    logic [CW-1:0] r_lo, r_hi, r_mid, r_ptr, r_count;
    logic [CW-1:0] n_lo, n_hi, n_mid;
    logic [CW-1:0] span, ptr_next, cnt_clamped;

    logic              r_done;
    t_status           r_status;
    logic [IDX_W-1:0]  r_route_index;

    logic [WW-1:0] used_ext, slot_ext;
    logic          slot_ok, wr_en, rd_lt, scope_ok;
    logic [AW-1:0] rd_addr;
    t_entry        wr_word;

    // Clamp the entry count to the table depth.
    assign used_ext    = WW'(i_cfg.entries_used);
    assign cnt_clamped = (used_ext > WW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : used_ext[CW-1:0];

    // Table write from a write command; slots beyond the table are dropped.
    assign slot_ext = WW'(i_entry_index);
    assign slot_ok  = slot_ext < WW'(TABLE_DEPTH);
    assign wr_en    = (i_cmd.op == CMD_ACCEPT) && (i_opcode == OP_WRITE) && slot_ok;

    always_comb begin
        wr_word.key          = i_source_key;
        wr_word.caller       = i_caller_addr;
        wr_word.context_addr = i_context_addr;
        wr_word.selector     = i_selector_value;
        wr_word.map_id       = i_map_number_in;
        wr_word.mask         = i_match_mask;
    end

    // Version and scope check on the held lookup word.
    assign scope_ok = (r_group == i_cfg.scope_group) &&
                      ((r_map == i_cfg.home_map) ||
                       ((r_map >= i_cfg.first_town) && (r_map <= i_cfg.last_town)));

    // One binary search step: narrow the window from the last probe, then pick the next probe.
    assign rd_lt = r_rd.key < r_key;

    always_comb begin
        if (i_cmd.op == CMD_SEARCH) begin
            n_lo = rd_lt ? (r_mid + CW'(1)) : r_lo;
            n_hi = rd_lt ? r_hi : r_mid;
        end else begin
            n_lo = r_lo;
            n_hi = r_hi;
        end
        span  = n_hi - n_lo;
        n_mid = n_lo + (span >> 1);
    end

    assign ptr_next = r_ptr + CW'(1);

    // Read address: next entry of the run while scanning, else the probe or the run start.
    always_comb begin
        if (i_cmd.op == CMD_SCAN) begin
            rd_addr = ptr_next[AW-1:0];
        end else if (n_lo < n_hi) begin
            rd_addr = n_mid[AW-1:0];
        end else begin
            rd_addr = n_lo[AW-1:0];
        end
    end

    // Status towards the controller.
    always_comb begin
        o_stat.reject  = (r_version != i_cfg.expected_version) || !scope_ok;
        o_stat.more    = n_lo < n_hi;
        o_stat.scan_ok = n_lo < r_count;
        o_stat.key_eq  = r_rd.key == r_key;
        o_stat.hit     = (!r_rd.mask[M_CALLER]   || (r_rd.caller == r_caller)) &&
                         (!r_rd.mask[M_CONTEXT]  || (r_rd.context_addr == r_context)) &&
                         (!r_rd.mask[M_SELECTOR] || (r_rd.selector == r_selector)) &&
                         (!r_rd.mask[M_MAP]      || (r_rd.map_id == r_map));
        o_stat.next_ok = ptr_next < r_count;
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[slot_ext[AW-1:0]] <= wr_word;
        end
        r_rd <= r_mem[rd_addr];
    end

    // Held lookup word, search window and scan pointer.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CMD_ACCEPT: begin
                r_key      <= i_source_key;
                r_caller   <= i_caller_addr;
                r_context  <= i_context_addr;
                r_selector <= i_selector_value;
                r_group    <= i_map_group_in;
                r_map      <= i_map_number_in;
                r_version  <= i_version_in;
                r_lo       <= '0;
                r_hi       <= cnt_clamped;
                r_count    <= cnt_clamped;
            end
            CMD_CHECK, CMD_SEARCH: begin
                r_lo  <= n_lo;
                r_hi  <= n_hi;
                r_mid <= n_mid;
                r_ptr <= n_lo;
            end
            CMD_SCAN: begin
                r_ptr <= ptr_next;
            end
            default: begin
            end
        endcase
    end

    // Result word register; the strobe lasts one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_status      <= i_cmd.fin_status;
            r_route_index <= (i_cmd.fin_status == ST_FOUND) ? IDX_W'(r_ptr) : '0;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_route_index = r_route_index;

    // A search step always works on a non-empty window inside the table.
    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == CMD_SEARCH) |-> (r_lo < r_hi) && (r_hi <= r_count))
        else $error("search step on an empty or oversized window");

    // The scan never reads past the valid entries.
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == CMD_SCAN) |-> (r_ptr < r_count))
        else $error("scan pointer beyond the valid entries");

    // A result other than found carries a zero index.
    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && (r_status != ST_FOUND)) |-> (r_route_index == '0))
        else $error("non-zero route index without a match");

endmodule

### sv/mkrl_ctrl.sv
module mkrl_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_opcode,
    input  mkrl_pkg::t_dp_status  i_stat,
    output logic                  o_busy,
    output mkrl_pkg::t_cmd        o_cmd
);
    import mkrl_pkg::*;

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && (i_opcode == OP_LOOKUP)) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.reject) begin
                    n_state = S_IDLE;
                end else if (i_stat.more) begin
                    n_state = S_SEARCH;
                end else if (i_stat.scan_ok) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SEARCH: begin
                if (i_stat.more) begin
                    n_state = S_SEARCH;
                end else if (i_stat.scan_ok) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_stat.key_eq && !i_stat.hit && i_stat.next_ok) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_busy           = 1'b1;
        o_cmd.op         = CMD_NONE;
        o_cmd.finish     = 1'b0;
        o_cmd.fin_status = ST_MISS;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.op = CMD_ACCEPT;
                    if (i_opcode == OP_WRITE) begin
                        o_cmd.finish     = 1'b1;
                        o_cmd.fin_status = ST_WRITTEN;
                    end
                end
            end
            S_CHECK: begin
                o_cmd.op = CMD_CHECK;
                if (i_stat.reject) begin
                    o_cmd.finish     = 1'b1;
                    o_cmd.fin_status = ST_REJECT;
                end else if (!i_stat.more && !i_stat.scan_ok) begin
                    o_cmd.finish     = 1'b1;
                    o_cmd.fin_status = ST_MISS;
                end
            end
            S_SEARCH: begin
                o_cmd.op = CMD_SEARCH;
                if (!i_stat.more && !i_stat.scan_ok) begin
                    o_cmd.finish     = 1'b1;
                    o_cmd.fin_status = ST_MISS;
                end
            end
            S_SCAN: begin
                o_cmd.op = CMD_SCAN;
                if (!i_stat.key_eq) begin
                    o_cmd.finish     = 1'b1;
                    o_cmd.fin_status = ST_MISS;
                end else if (i_stat.hit) begin
                    o_cmd.finish     = 1'b1;
                    o_cmd.fin_status = ST_FOUND;
                end else if (!i_stat.next_ok) begin
                    o_cmd.finish     = 1'b1;
                    o_cmd.fin_status = ST_MISS;
                end
            end
            default: begin
            end
        endcase
    end

    // A match can only be reported from the scan of the equal-key run.
    a_found_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.finish && (o_cmd.fin_status == ST_FOUND)) |-> (r_state == S_SCAN))
        else $error("match reported outside the scan");

    // A write is answered at once, on the edge that takes it.
    a_write_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.finish && (o_cmd.fin_status == ST_WRITTEN)) |->
        ((r_state == S_IDLE) && i_start && (i_opcode == OP_WRITE)))
        else $error("written status without a write command");

    // Finishing a lookup frees the block for the next word.
    a_finish_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.finish && (r_state != S_IDLE)) |=> !o_busy)
        else $error("block still busy after a lookup finished");

endmodule
